[sv/hmd_pkg.sv]
// Shared types, sizes and register codes of the histogram motion detector.
package hmd_pkg;

  // Histogram geometry
  localparam int BINS        = 16;
  localparam int HTILES      = 8;
  localparam int VTILES      = 8;
  localparam int TILE_TOTAL  = HTILES * VTILES;
  localparam int STORE_DEPTH = BINS * TILE_TOTAL;

  // Derived widths
  localparam int BIN_W   = $clog2(BINS);
  localparam int TILE_W  = $clog2(TILE_TOTAL);
  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int DIFF_W  = $clog2(BINS + 1);
  localparam int MOVE_W  = $clog2(TILE_TOTAL + 1);
  localparam int CNT_W   = 32;
  localparam int TIME_W  = 32;
  localparam int XY_W    = 3;
  localparam int RUN_W   = 16;
  localparam logic [RUN_W-1:0] RUN_MAX = '1;

  // Queue and result buffer sizes
  localparam int Q_DEPTH  = 4;
  localparam int Q_W      = $clog2(Q_DEPTH);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_W     = $clog2(OQ_DEPTH);

  // Register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_TILE_EVENTS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT_THR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_COUNT_THR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT_THR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_DIFF_THR     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL     = 3'd5;

  // Result kinds
  localparam logic KIND_TILE    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic              send_tile_events;
    logic [7:0]        frame_count_threshold;
    logic [6:0]        tile_count_threshold;
    logic [4:0]        bin_count_threshold;
    logic [31:0]       bin_diff_threshold;
    logic [9:0]        min_interval_ms;
  } cfg_t;

  // One classified bin on its way from front to back
  typedef struct packed {
    logic [CNT_W-1:0]  bin_count;
    logic [TIME_W-1:0] frame_time;
    logic [ADDR_W-1:0] addr;
    logic [TILE_W-1:0] tile;
    logic [XY_W-1:0]   tile_x;
    logic [XY_W-1:0]   tile_y;
    logic              first_bin;
    logic              last_bin;
    logic              first_tile;
    logic              last_tile;
  } item_t;

  typedef struct packed {
    logic              kind;
    logic [XY_W-1:0]   tile_x;
    logic [XY_W-1:0]   tile_y;
    logic [15:0]       count;
    logic              movement;
    logic [TIME_W-1:0] event_time;
    logic              last;
  } res_t;

endpackage

[sv/hmd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module hmd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a read of the address being written returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/hmd_front.sv]
// Front end: accepts bins, tracks frame position and decides frame skipping.
module hmd_front import hmd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              hist_valid,
  output logic              hist_stall,
  input  logic [CNT_W-1:0]  bin_count,
  input  logic [TIME_W-1:0] frame_time,
  input  logic              frame_start,
  input  logic              q_full,
  output logic              push,
  output item_t             push_item
);

  logic [BIN_W-1:0]  bin_pos;
  logic [TILE_W-1:0] tile_pos;
  logic [XY_W-1:0]   tx;
  logic [XY_W-1:0]   ty;
  logic [ADDR_W-1:0] addr;
  logic [TIME_W-1:0] last_time;
  logic              skipping;

  logic              take;
  logic              skip_now;
  logic              skip_eff;
  logic [TIME_W-1:0] gap;
  logic [BIN_W-1:0]  bin_cur;
  logic [TILE_W-1:0] tile_cur;
  logic [XY_W-1:0]   tx_cur;
  logic [XY_W-1:0]   ty_cur;
  logic [ADDR_W-1:0] addr_cur;
  logic              last_bin;
  logic              last_tile;

  assign hist_stall = q_full;
  assign take       = hist_valid && !q_full;

  // Frame start: skip when the gap to the last processed frame is too short
  assign gap      = frame_time - last_time;
  assign skip_now = (cfg.min_interval_ms != '0) && (gap < TIME_W'(cfg.min_interval_ms));
  assign skip_eff = frame_start ? skip_now : skipping;

  // Position of this item, restarting at a frame start
  assign bin_cur   = frame_start ? '0 : bin_pos;
  assign tile_cur  = frame_start ? '0 : tile_pos;
  assign tx_cur    = frame_start ? '0 : tx;
  assign ty_cur    = frame_start ? '0 : ty;
  assign addr_cur  = frame_start ? '0 : addr;
  assign last_bin  = (bin_cur == BIN_W'(BINS - 1));
  assign last_tile = (tile_cur == TILE_W'(TILE_TOTAL - 1));

  assign push = take && !skip_eff;

  always_comb begin
    push_item.bin_count  = bin_count;
    push_item.frame_time = frame_time;
    push_item.addr       = addr_cur;
    push_item.tile       = tile_cur;
    push_item.tile_x     = tx_cur;
    push_item.tile_y     = ty_cur;
    push_item.first_bin  = (bin_cur == '0);
    push_item.last_bin   = last_bin;
    push_item.first_tile = (tile_cur == '0);
    push_item.last_tile  = last_tile;
  end

  // Position and frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_pos   <= '0;
      tile_pos  <= '0;
      tx        <= '0;
      ty        <= '0;
      addr      <= '0;
      last_time <= '0;
      skipping  <= 1'b0;
    end else if (take) begin
      if (frame_start && (!skip_now || last_time == '0)) begin
        last_time <= frame_time;
      end
      if (skip_eff) begin
        skipping <= 1'b1;
        bin_pos  <= bin_cur;
        tile_pos <= tile_cur;
        tx       <= tx_cur;
        ty       <= ty_cur;
        addr     <= addr_cur;
      end else begin
        // frame complete: ignore items until the next frame start
        skipping <= last_bin && last_tile;
        addr     <= addr_cur + 1'b1;
        if (last_bin) begin
          bin_pos  <= '0;
          tile_pos <= tile_cur + 1'b1;
          if (tx_cur == XY_W'(HTILES - 1)) begin
            tx <= '0;
            ty <= ty_cur + 1'b1;
          end else begin
            tx <= tx_cur + 1'b1;
            ty <= ty_cur;
          end
        end else begin
          bin_pos  <= bin_cur + 1'b1;
          tile_pos <= tile_cur;
          tx       <= tx_cur;
          ty       <= ty_cur;
        end
      end
    end
  end

endmodule

[sv/hmd_queue.sv]
// Short item queue between the front end and the back end.
module hmd_queue import hmd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head_item
);

  item_t          entries [Q_DEPTH];
  logic [Q_W-1:0] wr_ptr;
  logic [Q_W-1:0] rd_ptr;
  logic [Q_W:0]   fill;

  assign full       = (fill == (Q_W+1)'(Q_DEPTH));
  assign head_valid = (fill != '0);
  assign head_item  = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + (Q_W+1)'(push) - (Q_W+1)'(pop);
    end
  end

endmodule

[sv/hmd_back.sv]
// Back end: bin compare against the stored histogram, tile runs and result buffer.
module hmd_back import hmd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              head_valid,
  input  item_t             head_item,
  output logic              pop,
  output logic              res_valid,
  input  logic              res_stall,
  output logic              kind,
  output logic [XY_W-1:0]   tile_x,
  output logic [XY_W-1:0]   tile_y,
  output logic [15:0]       count,
  output logic              movement,
  output logic [TIME_W-1:0] event_time,
  output logic              last
);

  logic              adv;
  logic [ADDR_W:0]   hist_fill;
  logic [TILE_W:0]   run_fill;
  logic [CNT_W-1:0]  hist_rdata;
  logic [RUN_W-1:0]  run_rdata;

  logic              b1_valid;
  item_t             b1_item;
  logic              b1_old_ok;
  logic [CNT_W-1:0]  b1_old;
  logic [CNT_W-1:0]  b1_abs;
  logic              b1_run_ok;

  logic              b2_valid;
  item_t             b2_item;
  logic [CNT_W-1:0]  b2_abs;
  logic              b2_run_ok;

  logic [DIFF_W-1:0] differing;
  logic [MOVE_W-1:0] moving_tiles;
  logic              hit;
  logic [DIFF_W-1:0] diff_cnt;
  logic              changed;
  logic [RUN_W-1:0]  run_old;
  logic [RUN_W-1:0]  run_new;
  logic              moving;
  logic [MOVE_W-1:0] move_cnt;
  logic              push_ev;
  logic              push_sm;
  res_t              ev_res;
  res_t              sm_res;

  res_t              oq [OQ_DEPTH];
  logic [OQ_W-1:0]   owr;
  logic [OQ_W-1:0]   ord;
  logic [OQ_W:0]     ocnt;
  logic              opop;

  // Whole pipeline moves only when the buffer can take two results
  assign adv = (ocnt <= (OQ_W+1)'(OQ_DEPTH - 2));
  assign pop = adv && head_valid;

  // Stage 0: read old count and write new count at the same address
  hmd_ram #(.WIDTH(CNT_W), .DEPTH(STORE_DEPTH)) u_hist (
    .clk   (clk),
    .we    (pop),
    .waddr (head_item.addr),
    .wdata (head_item.bin_count),
    .re    (adv),
    .raddr (head_item.addr),
    .rdata (hist_rdata)
  );

  // Entries are always written as a prefix from address zero
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_fill <= '0;
    end else if (pop && ({1'b0, head_item.addr} == hist_fill)) begin
      hist_fill <= hist_fill + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else if (adv) begin
      b1_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_item   <= head_item;
      b1_old_ok <= ({1'b0, head_item.addr} < hist_fill);
    end
  end

  // Stage 1: absolute difference, tile run read
  assign b1_old    = b1_old_ok ? hist_rdata : '0;
  assign b1_abs    = (b1_old > b1_item.bin_count) ? (b1_old - b1_item.bin_count)
                                                  : (b1_item.bin_count - b1_old);
  assign b1_run_ok = ({1'b0, b1_item.tile} < run_fill);

  hmd_ram #(.WIDTH(RUN_W), .DEPTH(TILE_TOTAL)) u_runs (
    .clk   (clk),
    .we    (adv && b2_valid && b2_item.last_bin),
    .waddr (b2_item.tile),
    .wdata (run_new),
    .re    (adv),
    .raddr (b1_item.tile),
    .rdata (run_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b2_valid <= 1'b0;
    end else if (adv) begin
      b2_valid <= b1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b2_item   <= b1_item;
      b2_abs    <= b1_abs;
      b2_run_ok <= b1_run_ok;
    end
  end

  // Stage 2: bin and tile decisions
  assign hit      = (b2_abs > cfg.bin_diff_threshold);
  assign diff_cnt = (b2_item.first_bin ? '0 : differing) + DIFF_W'(hit);
  assign changed  = (32'(diff_cnt) > 32'(cfg.bin_count_threshold));
  assign run_old  = b2_run_ok ? run_rdata : '0;
  assign moving   = (run_new > RUN_W'(cfg.frame_count_threshold));
  assign move_cnt = (b2_item.first_tile ? '0 : moving_tiles) + MOVE_W'(moving);

  always_comb begin
    if (!changed) begin
      run_new = '0;
    end else if (run_old == RUN_MAX) begin
      run_new = RUN_MAX;
    end else begin
      run_new = run_old + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      differing    <= '0;
      moving_tiles <= '0;
      run_fill     <= '0;
    end else if (adv && b2_valid) begin
      differing <= diff_cnt;
      if (b2_item.last_bin) begin
        moving_tiles <= move_cnt;
        if ({1'b0, b2_item.tile} == run_fill) begin
          run_fill <= run_fill + 1'b1;
        end
      end
    end
  end

  // Results of a finished tile
  assign push_ev = adv && b2_valid && b2_item.last_bin && moving && cfg.send_tile_events;
  assign push_sm = adv && b2_valid && b2_item.last_bin && b2_item.last_tile;

  always_comb begin
    ev_res.kind       = KIND_TILE;
    ev_res.tile_x     = b2_item.tile_x;
    ev_res.tile_y     = b2_item.tile_y;
    ev_res.count      = run_new;
    ev_res.movement   = 1'b0;
    ev_res.event_time = b2_item.frame_time;
    ev_res.last       = !b2_item.last_tile;
    sm_res.kind       = KIND_SUMMARY;
    sm_res.tile_x     = '0;
    sm_res.tile_y     = '0;
    sm_res.count      = 16'(move_cnt);
    sm_res.movement   = (32'(move_cnt) > 32'(cfg.tile_count_threshold));
    sm_res.event_time = b2_item.frame_time;
    sm_res.last       = 1'b1;
  end

  // Result buffer
  assign opop       = (ocnt != '0) && !res_stall;
  assign res_valid  = (ocnt != '0);
  assign kind       = oq[ord].kind;
  assign tile_x     = oq[ord].tile_x;
  assign tile_y     = oq[ord].tile_y;
  assign count      = oq[ord].count;
  assign movement   = oq[ord].movement;
  assign event_time = oq[ord].event_time;
  assign last       = oq[ord].last;

  always_ff @(posedge clk) begin
    if (push_ev) begin
      oq[owr] <= ev_res;
    end
    if (push_sm) begin
      oq[push_ev ? owr + 1'b1 : owr] <= sm_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owr  <= '0;
      ord  <= '0;
      ocnt <= '0;
    end else begin
      owr  <= owr + OQ_W'(push_ev) + OQ_W'(push_sm);
      if (opop) begin
        ord <= ord + 1'b1;
      end
      ocnt <= ocnt + (OQ_W+1)'(push_ev) + (OQ_W+1)'(push_sm) - (OQ_W+1)'(opop);
    end
  end

  // Checks
  a_oq_bound: assert property (@(posedge clk) disable iff (rst)
    ocnt <= (OQ_W+1)'(OQ_DEPTH))
    else $error("result buffer overfilled");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(b1_valid) && $stable(b2_valid))
    else $error("pipeline moved while frozen");

  a_fill_grows: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> hist_fill >= $past(hist_fill))
    else $error("histogram fill count went backwards");

  a_two_results: assert property (@(posedge clk) disable iff (rst)
    push_ev && push_sm |-> b2_item.last_tile && b2_item.last_bin)
    else $error("two results outside the frame's final tile");

endmodule

[sv/histogram_motion_detector_core.sv]
// Top level of the tile histogram motion detector: registers and block wiring.
//
//  channel | direction | handshake             | payload
//  hist    | in        | hist_valid/hist_stall | bin_count, frame_time, frame_start
//  res     | out       | res_valid/res_stall   | kind, tile_x, tile_y, count,
//          |           |                       | movement, event_time, last
//  cfg     | in        | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// One bin item per cycle sustained unless the queue or the result buffer stalls;
// a tile's last bin gives its results via front, queue head, compare, tile decision.
// The histogram store has one read and one write port per cycle; that port sets
// the rate. No clearing pass after reset: fill counts mark the written entries.
// The back end halts while the result buffer has fewer than two free places;
// hist_stall rises when the four-item queue is full. cfg_ready is always high.
module histogram_motion_detector_core import hmd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 hist_valid,
  output logic                 hist_stall,
  input  logic [CNT_W-1:0]     bin_count,
  input  logic [TIME_W-1:0]    frame_time,
  input  logic                 frame_start,
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic                 kind,
  output logic [XY_W-1:0]      tile_x,
  output logic [XY_W-1:0]      tile_y,
  output logic [15:0]          count,
  output logic                 movement,
  output logic [TIME_W-1:0]    event_time,
  output logic                 last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cfg_t  cfg;
  logic  q_full;
  logic  push;
  item_t push_item;
  logic  pop;
  logic  head_valid;
  item_t head_item;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.send_tile_events      <= 1'b0;
      cfg.frame_count_threshold <= 8'd4;
      cfg.tile_count_threshold  <= 7'd1;
      cfg.bin_count_threshold   <= 5'd2;
      cfg.bin_diff_threshold    <= 32'd100;
      cfg.min_interval_ms       <= 10'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SEND_TILE_EVENTS: cfg.send_tile_events      <= cfg_data[0];
        CFG_FRAME_COUNT_THR:  cfg.frame_count_threshold <= cfg_data[7:0];
        CFG_TILE_COUNT_THR:   cfg.tile_count_threshold  <= cfg_data[6:0];
        CFG_BIN_COUNT_THR:    cfg.bin_count_threshold   <= cfg_data[4:0];
        CFG_BIN_DIFF_THR:     cfg.bin_diff_threshold    <= cfg_data;
        CFG_MIN_INTERVAL:     cfg.min_interval_ms       <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  hmd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .hist_valid  (hist_valid),
    .hist_stall  (hist_stall),
    .bin_count   (bin_count),
    .frame_time  (frame_time),
    .frame_start (frame_start),
    .q_full      (q_full),
    .push        (push),
    .push_item   (push_item)
  );

  hmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  hmd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .kind       (kind),
    .tile_x     (tile_x),
    .tile_y     (tile_y),
    .count      (count),
    .movement   (movement),
    .event_time (event_time),
    .last       (last)
  );

endmodule

[tb/sv/histogram_motion_detector_core_tb.sv]
// Self-checking testbench for the tile histogram motion detector core.
module histogram_motion_detector_core_tb;
  import hmd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_BINS   = BINS * TILE_TOTAL;
  localparam int SETTLE       = 40;       // pipeline plus input queue, generously
  localparam int HOLD_CYCLES  = 3000;     // long receiver hold-off
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic [CNT_W-1:0]  bin_count;
    logic [TIME_W-1:0] frame_time;
    logic              frame_start;
  } hist_item_t;

  // DUT connections
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 hist_valid = 1'b0;
  logic                 hist_stall;
  logic [CNT_W-1:0]     bin_count = '0;
  logic [TIME_W-1:0]    frame_time = '0;
  logic                 frame_start = 1'b0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  logic                 kind;
  logic [XY_W-1:0]      tile_x;
  logic [XY_W-1:0]      tile_y;
  logic [15:0]          count;
  logic                 movement;
  logic [TIME_W-1:0]    event_time;
  logic                 last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  histogram_motion_detector_core dut (.*);

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pending stimulus and expected results
  hist_item_t pending_bins[$];
  res_t       due_reports[$];
  hist_item_t on_offer;
  int         failures = 0;

  // Motion model state and its copy of the registers
  logic [CNT_W-1:0] hist_store [STORE_DEPTH];
  logic [RUN_W-1:0] run_len [TILE_TOTAL];
  int               bin_at = 0;
  int               tile_at = 0;
  int               changed_bins = 0;
  int               moving_count = 0;
  logic [31:0]      processed_time = '0;
  bit               frame_done = 1'b0;
  cfg_t             mdl_cfg;

  // Stimulus shaping
  logic [31:0] tile_level [TILE_TOTAL];
  int          moving_bins [TILE_TOTAL];
  logic [31:0] flip_mask;
  logic [31:0] clock_ms = '0;
  bit          odd_frame = 1'b0;

  // Idling
  int send_gap = 0;
  int send_calm = 0;
  int recv_wait = 0;
  int recv_calm = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit hold_request = 1'b0;
  int unsigned cycle_no = 0;

  function automatic cfg_t make_cfg(logic send, logic [7:0] fct, logic [6:0] tct,
                                    logic [4:0] bct, logic [31:0] bdt, logic [9:0] mi);
    cfg_t c;
    c.send_tile_events      = send;
    c.frame_count_threshold = fct;
    c.tile_count_threshold  = tct;
    c.bin_count_threshold   = bct;
    c.bin_diff_threshold    = bdt;
    c.min_interval_ms       = mi;
    return c;
  endfunction

  // Wait per item: mostly drawn at random, with occasional stretches of none
  function automatic int next_wait(ref int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm_left = $urandom_range(20, 120);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  // Expected results of one accepted bin item
  function automatic void track_motion(hist_item_t it);
    logic [31:0]      elapsed;
    logic [31:0]      old_cnt;
    logic [31:0]      delta;
    logic [RUN_W-1:0] run;
    res_t             rep;
    int               idx;
    bit               tile_evt;
    if (it.frame_start) begin
      bin_at = 0;
      tile_at = 0;
      changed_bins = 0;
      moving_count = 0;
      elapsed = it.frame_time - processed_time;
      if (mdl_cfg.min_interval_ms != 0 && elapsed < 32'(mdl_cfg.min_interval_ms)) begin
        // too soon: skip, but the first skipped frame after a zero time seeds it
        if (processed_time == 0) processed_time = it.frame_time;
        frame_done = 1'b1;
      end else begin
        processed_time = it.frame_time;
        frame_done = 1'b0;
      end
    end
    if (frame_done || tile_at >= TILE_TOTAL || bin_at >= BINS) return;

    // bin compare against the stored histogram
    idx = tile_at * BINS + bin_at;
    old_cnt = hist_store[idx];
    delta = (old_cnt > it.bin_count) ? old_cnt - it.bin_count : it.bin_count - old_cnt;
    if (delta > mdl_cfg.bin_diff_threshold) changed_bins++;
    hist_store[idx] = it.bin_count;
    bin_at++;
    if (bin_at < BINS) return;

    // tile decision
    run = run_len[tile_at];
    if (changed_bins > mdl_cfg.bin_count_threshold)
      run = (run != RUN_MAX) ? run + 1'b1 : RUN_MAX;
    else
      run = '0;
    run_len[tile_at] = run;
    tile_evt = 1'b0;
    rep = '0;
    if (run > mdl_cfg.frame_count_threshold) begin
      moving_count++;
      if (mdl_cfg.send_tile_events) begin
        rep.kind       = KIND_TILE;
        rep.tile_x     = XY_W'(tile_at % HTILES);
        rep.tile_y     = XY_W'(tile_at / HTILES);
        rep.count      = run;
        rep.event_time = it.frame_time;
        tile_evt = 1'b1;
      end
    end
    changed_bins = 0;
    bin_at = 0;
    tile_at++;
    if (tile_evt) begin
      rep.last = (tile_at < TILE_TOTAL);
      due_reports.push_back(rep);
    end

    // frame summary after the last tile
    if (tile_at >= TILE_TOTAL) begin
      rep = '0;
      rep.kind       = KIND_SUMMARY;
      rep.count      = 16'(moving_count);
      rep.movement   = (moving_count > mdl_cfg.tile_count_threshold);
      rep.event_time = it.frame_time;
      rep.last       = 1'b1;
      due_reports.push_back(rep);
      frame_done = 1'b1;
    end
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endfunction

  function automatic void push_bin(logic [31:0] c, logic [31:0] t, logic s);
    hist_item_t it;
    it.bin_count   = c;
    it.frame_time  = t;
    it.frame_start = s;
    pending_bins.push_back(it);
  endfunction

  // New tile contents for a phase
  function automatic void shape_tiles();
    foreach (tile_level[i]) begin
      tile_level[i]  = $urandom;
      moving_bins[i] = $urandom_range(0, BINS);
    end
    flip_mask = $urandom | 32'h0001_0000;
  endfunction

  // One frame of len items; moving bins toggle every other frame
  function automatic void queue_frame(logic [31:0] t, int len);
    bit          jitter;
    int          tile;
    int          slot;
    logic [31:0] lvl;
    logic [31:0] val;
    logic [31:0] stamp;
    jitter = ($urandom_range(0, 9) == 0);
    odd_frame = !odd_frame;
    repeat (4) moving_bins[$urandom_range(0, TILE_TOTAL-1)] = $urandom_range(0, BINS);
    for (int i = 0; i < len; i++) begin
      tile = (i / BINS) % TILE_TOTAL;
      slot = i % BINS;
      lvl = tile_level[tile];
      if (odd_frame && slot < moving_bins[tile]) lvl = lvl ^ flip_mask;
      val = lvl + $urandom_range(0, 63);
      if ($urandom_range(0, 63) == 0) val = $urandom;
      stamp = (jitter && $urandom_range(0, 3) == 0) ? $urandom : t;
      push_bin(val, stamp, (i == 0));
    end
  endfunction

  // n_frames short frames over the first few tiles, broken off in mid-frame;
  // frames that come too early are shorter still
  function automatic void run_frames(int n_frames);
    int          len;
    int          gap;
    logic [31:0] mi;
    for (int f = 0; f < n_frames; f++) begin
      mi = 32'(mdl_cfg.min_interval_ms);
      gap = (mi == 0) ? $urandom_range(0, 3000) : $urandom_range(0, 2 * mi);
      clock_ms += gap;
      if ($urandom_range(0, 7) == 0) clock_ms = $urandom;
      if (mi != 0 && gap < mi) begin
        len = $urandom_range(1, BINS);
      end else begin
        len = $urandom_range(BINS + 1, 3 * BINS);
      end
      queue_frame(clock_ms, len);
    end
  endfunction

  // Block idle: everything sent, every result back, pipeline emptied
  task automatic drain();
    while (pending_bins.size() != 0 || hist_valid || due_reports.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Write all six registers, one item per handshake
  task automatic load_settings(cfg_t s);
    logic [CFG_IDX_W-1:0] reg_id [6];
    logic [31:0]          reg_val [6];
    reg_id  = '{CFG_SEND_TILE_EVENTS, CFG_FRAME_COUNT_THR, CFG_TILE_COUNT_THR,
                CFG_BIN_COUNT_THR, CFG_BIN_DIFF_THR, CFG_MIN_INTERVAL};
    reg_val = '{32'(s.send_tile_events), 32'(s.frame_count_threshold),
                32'(s.tile_count_threshold), 32'(s.bin_count_threshold),
                s.bin_diff_threshold, 32'(s.min_interval_ms)};
    @(posedge clk);
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_id[i];
      cfg_data  <= reg_val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    mdl_cfg = s;
  endtask

  // Input driver
  always @(posedge clk) begin
    if (rst) begin
      hist_valid  <= 1'b0;
      bin_count   <= '0;
      frame_time  <= '0;
      frame_start <= 1'b0;
      send_gap    <= 0;
    end else begin
      if (hist_valid && !hist_stall) track_motion(on_offer);
      if (!hist_valid || !hist_stall) begin
        if (send_gap != 0) begin
          hist_valid <= 1'b0;
          send_gap   <= send_gap - 1;
        end else if (pending_bins.size() != 0) begin
          on_offer = pending_bins.pop_front();
          hist_valid  <= 1'b1;
          bin_count   <= on_offer.bin_count;
          frame_time  <= on_offer.frame_time;
          frame_start <= on_offer.frame_start;
          send_gap    <= next_wait(send_calm);
        end else begin
          hist_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall
  always @(posedge clk) begin : take_results
    res_t want;
    int   w;
    if (rst) begin
      res_stall <= 1'b0;
      recv_wait <= 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (due_reports.size() == 0) begin
          $error("result with none expected: kind %0b count %0d", kind, count);
          failures++;
        end else begin
          want = due_reports.pop_front();
          compare_field("kind", want.kind, kind);
          compare_field("tile_x", want.tile_x, tile_x);
          compare_field("tile_y", want.tile_y, tile_y);
          compare_field("count", want.count, count);
          compare_field("movement", want.movement, movement);
          compare_field("event_time", want.event_time, event_time);
          compare_field("last", want.last, last);
        end
        w = next_wait(recv_calm);
      end else begin
        w = (recv_wait > 0) ? recv_wait - 1 : 0;
      end
      recv_wait <= w;
      res_stall <= (w != 0) || (hold_left != 0);
    end
  end

  // One long hold-off on the result side so the block backs up
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Test sequence
  initial begin : run_plan
    logic [31:0] corner_counts [16];
    corner_counts = '{32'h0, 32'hFFFF_FFFF, 32'd100, 32'd101, 32'd99, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'd1, 32'd200, 32'd55, 32'h0, 32'h0,
                      32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'd1000, 32'd64};
    foreach (hist_store[i]) hist_store[i] = '0;
    foreach (run_len[i]) run_len[i] = '0;
    mdl_cfg = make_cfg(1'b0, 8'd4, 7'd1, 5'd2, 32'd100, 10'd0);
    shape_tiles();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: a tile before any frame start, count extremes and the
    // threshold boundary, then two frame starts in mid-frame
    for (int i = 0; i < BINS; i++)
      push_bin(corner_counts[i], (i % 2) ? 32'hFFFF_FFFF : 32'h0, 1'b0);
    push_bin($urandom, 32'hFFFF_FFFF, 1'b1);
    repeat (4) push_bin($urandom, 32'hFFFF_FFFF, 1'b0);
    push_bin($urandom, 32'h0, 1'b1);
    repeat (2) push_bin($urandom, 32'h0, 1'b0);
    drain();

    // Interval of 1000 ms, unreachable bin threshold: skipping at the boundary
    load_settings(make_cfg(1'b1, 8'd1, 7'd64, 5'd16, 32'd1000, 10'd1000));
    @(negedge clk);
    queue_frame(32'd300, 2 * BINS);
    queue_frame(32'd1299, 2 * BINS);
    queue_frame(32'd1300, 2 * BINS);
    queue_frame(32'd2299, 2 * BINS);
    queue_frame(32'd2300, 2 * BINS);
    clock_ms = 32'd2300;
    drain();

    // All thresholds at zero: every tile moves; one whole frame with a few
    // items past its end, and the long result hold-off here
    load_settings(make_cfg(1'b1, 8'd0, 7'd0, 5'd0, 32'd0, 10'd0));
    @(negedge clk);
    hold_request = 1'b1;
    shape_tiles();
    clock_ms += 32'd500;
    queue_frame(clock_ms, FRAME_BINS + 3);
    drain();

    // Mid settings: runs grow past the frame threshold
    load_settings(make_cfg(1'b1, 8'd2, 7'd5, 5'd7, 32'd100, 10'd50));
    @(negedge clk);
    shape_tiles();
    run_frames(4);
    drain();

    // High thresholds and a 1 ms interval, tile events off
    load_settings(make_cfg(1'b0, 8'd255, 7'd63, 5'd15, 32'hFFFF_FFFF, 10'd1));
    @(negedge clk);
    shape_tiles();
    run_frames(1);
    drain();

    // Random settings
    load_settings(make_cfg(1'b1, 8'($urandom_range(0, 3)), 7'($urandom_range(0, 64)),
                           5'($urandom_range(0, 16)), $urandom_range(0, 300),
                           10'($urandom_range(0, 1000))));
    @(negedge clk);
    shape_tiles();
    run_frames(2);
    drain();

    if (failures == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
